// ===== rtl/core/ilc_pkg.sv =====
// shared constants, codes and types for the indexed list with compaction
// no dependencies
`default_nettype none

package ilc_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int INDEX_WIDTH = $clog2(CAPACITY);
  localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
  localparam int CMD_WIDTH   = 2;
  localparam int ST_WIDTH    = 2;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CMD_WIDTH-1:0]   cmd_t;
  typedef logic [ST_WIDTH-1:0]    status_t;

  // request commands
  localparam cmd_t CMD_GET    = 2'd0;
  localparam cmd_t CMD_SET    = 2'd1;
  localparam cmd_t CMD_APPEND = 2'd2;
  localparam cmd_t CMD_DELETE = 2'd3;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/ilc_ram.sv =====
// generic simple dual-port ram, one write port, one read port with registered data
// no dependencies
`default_nettype none

module ilc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_with_compaction.sv =====
// top level of the indexed list with compaction: control sequencer around one entry ram
// depends on ilc_pkg and ilc_ram
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  cmd, index, value
//   out      out  out_valid / out_stall read_value, status, count
//
// set, append and any rejected request: the result goes from the result state into the output register
// get: an extra wait state first, for the registered ram read
// delete: a shift state first, in which the tail moves down one entry a cycle through the
//   single ram read and write port; no entry moves when the last entry goes
// rst clears the length, the state, the pending shift write and out_valid; ram contents stay undefined until written
// input is taken whenever the sequencer is idle, even while a result waits on out_stall;
//   a finished request waits in the result state while an earlier result is still stalled
`default_nettype none

module indexed_list_with_compaction
  import ilc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  cmd_t       cmd,
  input  index_t     index,
  input  value_t     value,
  output logic       out_valid,
  input  logic       out_stall,
  output value_t     read_value,
  output status_t    status,
  output count_t     count
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GETW  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state;
  count_t     used_count;

  // delete shift pointers: rptr reads ahead, wr_ptr trails one entry behind
  count_t     rptr;
  logic       wr_pend;
  index_t     wr_ptr;

  // result held until the output register frees up
  value_t     res_value;
  status_t    res_status;

  logic       accept;
  logic       in_range;
  logic       full;
  logic       out_free;

  logic       ram_we;
  index_t     ram_waddr;
  value_t     ram_wdata;
  index_t     ram_raddr;
  value_t     ram_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign in_range = (COUNT_WIDTH'(index) < used_count);
  assign full     = (used_count == COUNT_WIDTH'(CAPACITY));
  // output beat slot can take a new result this cycle
  assign out_free = !out_valid || !out_stall;

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = ram_rdata;
    ram_raddr = rptr[INDEX_WIDTH-1:0];
    case (state)
      S_IDLE: begin
        // a get reads straight from the request index
        ram_raddr = index;
        if (accept && (cmd == CMD_SET) && in_range) begin
          ram_we    = 1'b1;
          ram_waddr = index;
          ram_wdata = value;
        end else if (accept && (cmd == CMD_APPEND) && !full) begin
          ram_we    = 1'b1;
          ram_waddr = used_count[INDEX_WIDTH-1:0];
          ram_wdata = value;
        end
      end
      S_SHIFT: begin
        // entry read last cycle lands one place lower
        ram_we = wr_pend;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ilc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // result state reloads the slot itself when it frees up
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            case (cmd)
              CMD_GET: begin
                if (in_range) begin
                  res_status <= ST_OK;
                  state      <= S_GETW;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_RESP;
                end
              end
              CMD_SET: begin
                res_status <= in_range ? ST_OK : ST_RANGE;
                state      <= S_RESP;
              end
              CMD_APPEND: begin
                state <= S_RESP;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  used_count <= used_count + COUNT_WIDTH'(1);
                end
              end
              CMD_DELETE: begin
                if (in_range) begin
                  res_status <= ST_OK;
                  rptr       <= COUNT_WIDTH'(index) + COUNT_WIDTH'(1);
                  wr_pend    <= 1'b0;
                  state      <= S_SHIFT;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_RESP;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_GETW: begin
          res_value <= ram_rdata;
          state     <= S_RESP;
        end
        S_SHIFT: begin
          if (rptr < used_count) begin
            wr_pend <= 1'b1;
            wr_ptr  <= INDEX_WIDTH'(rptr - COUNT_WIDTH'(1));
            rptr    <= rptr + COUNT_WIDTH'(1);
          end else begin
            wr_pend <= 1'b0;
            // last move has been written, list is one shorter
            if (!wr_pend) begin
              used_count <= used_count - COUNT_WIDTH'(1);
              state      <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_value <= res_value;
            status     <= res_status;
            count      <= used_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= COUNT_WIDTH'(CAPACITY))
    else $error("list length beyond capacity");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (used_count == $past(used_count)
      || used_count == $past(used_count) + COUNT_WIDTH'(1)
      || used_count == $past(used_count) - COUNT_WIDTH'(1)))
    else $error("list length moved by more than one");

  a_shift_wr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && wr_pend) |-> (COUNT_WIDTH'(wr_ptr) < used_count))
    else $error("shift write outside the list");

  a_shift_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (rptr <= used_count))
    else $error("shift read pointer past the end");

  a_out_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
    else $error("undefined status code on output");
`endif

endmodule

`default_nettype wire
